// ----- src/one_shot_sample_voice_mixer_macros.svh -----
// Assertion macros for the voice mixer. They compile to nothing under synthesis.
`ifndef ONE_SHOT_SAMPLE_VOICE_MIXER_MACROS_SVH
`define ONE_SHOT_SAMPLE_VOICE_MIXER_MACROS_SVH

`ifndef SYNTHESIS

`define OSVM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define OSVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define OSVM_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define OSVM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/osvm_pkg.sv -----
package osvm_pkg;

  localparam int WORD_W      = 16;
  localparam int LENGTH_W    = 15;
  localparam int VOICE_W     = 3;
  localparam int ADDR_IN_W   = 14;
  localparam int OP_W        = 2;
  localparam int LENGTH_REGS = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = LENGTH_W;
  localparam int POS_W       = LENGTH_W + 1;

  // Division by six as a multiply by a rounded-up reciprocal and a shift.
  localparam int RECIP_SHIFT = 18;
  localparam logic [WORD_W-1:0] RECIP_6 = 16'd43691;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TRIGGER = 2'd1;
  localparam logic [OP_W-1:0] OP_FRAME   = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [LENGTH_W-1:0] length_t;

  typedef struct packed {
    logic valid;
    logic gate;
    logic side;
  } tag_t;

endpackage

// ----- src/osvm_if.sv -----
interface osvm_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [osvm_pkg::OP_W-1:0]       operation;
  logic [osvm_pkg::VOICE_W-1:0]    voice;
  logic [osvm_pkg::ADDR_IN_W-1:0]  sample_address;
  osvm_pkg::word_t                 sample_value;

  modport source (output valid, output operation, output voice,
                  output sample_address, output sample_value, input ready);
  modport sink (input valid, input operation, input voice,
                input sample_address, input sample_value, output ready);
endinterface

interface osvm_mix_if;
  logic            valid;
  logic            ready;
  osvm_pkg::word_t left_mix;
  osvm_pkg::word_t right_mix;

  modport source (output valid, output left_mix, output right_mix, input ready);
  modport sink (input valid, input left_mix, input right_mix, output ready);
endinterface

// ----- src/osvm_sample_ram.sv -----
module osvm_sample_ram #(
  parameter int DEPTH = 98304,
  parameter int AW    = 17
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  osvm_pkg::word_t     wdata,
  input  logic [AW-1:0]       raddr,
  output osvm_pkg::word_t     rdata
);
  import osvm_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/osvm_div6.sv -----
module osvm_div6 (
  input  logic             clk,
  input  logic             rst,
  input  osvm_pkg::word_t  word,
  input  osvm_pkg::tag_t   tag_in,
  output osvm_pkg::word_t  quot,
  output osvm_pkg::tag_t   tag_out
);
  import osvm_pkg::*;

  logic [WORD_W-1:0]   mag;
  logic [2*WORD_W-1:0] prod;
  logic                neg;
  logic [2*WORD_W-RECIP_SHIFT-1:0] qmag;

  // Words that fall outside the voice length enter as zero.
  always_comb begin
    if (!tag_in.gate) begin
      mag = '0;
    end else if (word[WORD_W-1]) begin
      mag = WORD_W'(-word);
    end else begin
      mag = WORD_W'(word);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    prod <= (2*WORD_W)'(mag) * (2*WORD_W)'(RECIP_6);
    neg  <= tag_in.gate & word[WORD_W-1];
  end

  assign qmag = prod[2*WORD_W-1:RECIP_SHIFT];
  assign quot = neg ? -word_t'(WORD_W'(qmag)) : word_t'(WORD_W'(qmag));

endmodule

// ----- src/one_shot_sample_voice_mixer.sv -----
// Channel  Role    Payload
// cmd      sink    operation, voice, sample_address, sample_value
// mix      source  left_mix, right_mix (one transaction per frame command)
//
// Load, trigger and unused commands complete in the cycle they are accepted.
// During a frame, one shared divide-by-six multiplier sees one word per cycle
// from the single RAM read port.
// Reset is synchronous; it idles all voices and needs no memory clearing pass.
// A waiting mix transaction stalls only the end of the next frame command.
module one_shot_sample_voice_mixer #(
  parameter int VOICE_COUNT     = 6,
  parameter int WORDS_PER_VOICE = 16384
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [osvm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [osvm_pkg::CFG_DATA_W-1:0]   cfg_data,
  osvm_cmd_if.sink                          cmd,
  osvm_mix_if.source                        mix
);
  import osvm_pkg::*;
  `include "one_shot_sample_voice_mixer_macros.svh"

  localparam int DEPTH = VOICE_COUNT * WORDS_PER_VOICE;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [QW-1:0] LAST_VOICE = QW'(VOICE_COUNT - 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_t;

  state_t  state;
  length_t length [VOICE_COUNT];
  length_t pos [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] active;
  logic [QW-1:0] q;
  logic    side;
  tag_t    tag0;
  tag_t    tag1;
  word_t   quot;
  word_t   rdata;
  word_t   sum_left;
  word_t   sum_right;
  word_t   left_out;
  word_t   right_out;
  logic    mix_valid;

  logic             accept;
  logic             voice_ok;
  logic             load_we;
  logic [AW-1:0]    waddr;
  logic [QW-1:0]    cmd_q;
  logic [POS_W-1:0] pos_rd;
  logic [POS_W-1:0] pos_adv;
  logic             rd_ok;
  logic [AW-1:0]    raddr;

  assign accept   = cmd.valid && cmd.ready;
  assign voice_ok = 32'(cmd.voice) < VOICE_COUNT;
  assign cmd_q    = cmd.voice[QW-1:0];
  assign load_we  = accept && cmd.operation == OP_LOAD && voice_ok &&
                    32'(cmd.sample_address) < WORDS_PER_VOICE;
  assign waddr    = AW'(cmd_q) * AW'(WORDS_PER_VOICE) + AW'(cmd.sample_address);

  assign pos_rd  = {1'b0, pos[q]} + POS_W'(side);
  assign pos_adv = {1'b0, pos[q]} + POS_W'(2);
  assign rd_ok   = active[q] && pos_rd < {1'b0, length[q]} &&
                   32'(pos_rd) < WORDS_PER_VOICE;
  assign raddr   = rd_ok ? AW'(q) * AW'(WORDS_PER_VOICE) + AW'(pos_rd) : '0;

  osvm_sample_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (cmd.sample_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  osvm_div6 u_div6 (
    .clk     (clk),
    .rst     (rst),
    .word    (rdata),
    .tag_in  (tag0),
    .quot    (quot),
    .tag_out (tag1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        length[i] <= '0;
      end
    end else if (cfg_we && 32'(cfg_index) < LENGTH_REGS &&
                 32'(cfg_index) < VOICE_COUNT) begin
      length[cfg_index[QW-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      mix_valid <= 1'b0;
      tag0      <= '0;
      q         <= '0;
      side      <= 1'b0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        pos[i] <= '0;
      end
    end else begin
      if (state == S_RUN) begin
        tag0 <= '{valid: 1'b1, gate: rd_ok, side: side};
      end else begin
        tag0 <= '0;
      end
      if (mix_valid && mix.ready && state != S_OUT) begin
        mix_valid <= 1'b0;
      end
      if (tag1.valid) begin
        if (tag1.side) begin
          sum_right <= sum_right + quot;
        end else begin
          sum_left <= sum_left + quot;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.operation == OP_TRIGGER && voice_ok) begin
              pos[cmd_q]    <= '0;
              active[cmd_q] <= 1'b1;
            end else if (cmd.operation == OP_FRAME) begin
              q         <= '0;
              side      <= 1'b0;
              sum_left  <= '0;
              sum_right <= '0;
              state     <= S_RUN;
            end
          end
        end
        S_RUN: begin
          side <= ~side;
          if (side) begin
            if (active[q]) begin
              if (pos_adv >= {1'b0, length[q]}) begin
                active[q] <= 1'b0;
                pos[q]    <= '0;
              end else begin
                pos[q] <= pos_adv[LENGTH_W-1:0];
              end
            end
            if (q == LAST_VOICE) begin
              state <= S_DRAIN;
            end else begin
              q <= q + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          if (!tag0.valid && !tag1.valid) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!mix_valid || mix.ready) begin
            left_out  <= sum_left;
            right_out <= sum_right;
            mix_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready     = (state == S_IDLE);
  assign mix.valid     = mix_valid;
  assign mix.left_mix  = left_out;
  assign mix.right_mix = right_out;

  `OSVM_ASSERT_IMPLY(a_idle_pipe_empty, clk, rst, cmd.ready, !tag0.valid && !tag1.valid)
  `OSVM_ASSERT_NEXT(a_frame_busy, clk, rst, accept && cmd.operation == OP_FRAME, !cmd.ready)
  `OSVM_ASSERT_IMPLY(a_words_in_frame, clk, rst, tag1.valid, state == S_RUN || state == S_DRAIN)

endmodule

// ----- verif/tb_one_shot_sample_voice_mixer.sv -----
module tb_one_shot_sample_voice_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  import osvm_pkg::*;

  localparam int VOICES = 6;
  localparam int WORDS = 16384;
  localparam int DIVISOR = 6;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 960;
  localparam int PHASES = 6;

  typedef struct packed {
    word_t left;
    word_t right;
  } stereo_mix_t;

  typedef int length_set_t [VOICES];

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  osvm_cmd_if cmd_ch ();
  osvm_mix_if mix_ch ();

  one_shot_sample_voice_mixer #(
    .VOICE_COUNT(VOICES),
    .WORDS_PER_VOICE(WORDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd_ch),
    .mix(mix_ch)
  );

  word_t voice_mem [VOICES][WORDS];
  bit word_loaded [VOICES][WORDS];
  length_t voice_len [VOICES];
  int voice_pos [VOICES];
  bit voice_on [VOICES];
  stereo_mix_t mix_expected [$];

  int mismatches = 0;
  int gap_pct = 30;
  int stall_pct = 30;
  int sink_stall = 0;
  int counted_items = 0;

  always #5 clk = ~clk;

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(0, 24);
    if (r < 70) return $urandom_range(25, 300);
    if (r < 80) return WORDS;
    if (r < 90) return $urandom_range(0, 32767);
    return $urandom_range(0, 1);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic check_mix(word_t got_l, word_t got_r);
    stereo_mix_t want;
    if (mix_expected.size() == 0) begin
      note_mismatch($sformatf("mix transaction with no frame pending: left %0d right %0d",
                              got_l, got_r));
    end else begin
      want = mix_expected.pop_front();
      if (got_l !== want.left)
        note_mismatch($sformatf("left_mix: expected %0d, got %0d", want.left, got_l));
      if (got_r !== want.right)
        note_mismatch($sformatf("right_mix: expected %0d, got %0d", want.right, got_r));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && mix_ch.valid && mix_ch.ready) check_mix(mix_ch.left_mix, mix_ch.right_mix);
    if (sink_stall > 0) sink_stall--;
    else sink_stall = pick_gap(stall_pct);
    mix_ch.ready <= (sink_stall == 0);
  end

  function automatic int fetch_word(int v, int p);
    if (p >= voice_len[v] || p >= WORDS) return 0;
    return voice_mem[v][p];
  endfunction

  task automatic predict_cmd(logic [OP_W-1:0] op, logic [VOICE_W-1:0] v,
                             logic [ADDR_IN_W-1:0] addr, word_t val);
    int sum_l;
    int sum_r;
    int p;
    stereo_mix_t m;
    case (op)
      OP_LOAD: begin
        if (v < VOICES) begin
          voice_mem[v][addr] = val;
          word_loaded[v][addr] = 1'b1;
        end
      end
      OP_TRIGGER: begin
        if (v < VOICES) begin
          voice_pos[v] = 0;
          voice_on[v] = 1'b1;
        end
      end
      OP_FRAME: begin
        sum_l = 0;
        sum_r = 0;
        for (int q = 0; q < VOICES; q++) begin
          if (voice_on[q]) begin
            p = voice_pos[q];
            sum_l += fetch_word(q, p) / DIVISOR;
            sum_r += fetch_word(q, p + 1) / DIVISOR;
            p += 2;
            if (p >= voice_len[q]) begin
              voice_on[q] = 1'b0;
              p = 0;
            end
            voice_pos[q] = p;
          end
        end
        m.left = sum_l[15:0];
        m.right = sum_r[15:0];
        mix_expected.push_back(m);
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(logic [OP_W-1:0] op, int v, int addr, int val);
    int gap;
    logic [VOICE_W-1:0] vf;
    logic [ADDR_IN_W-1:0] af;
    word_t wf;
    gap = pick_gap(gap_pct);
    vf = VOICE_W'(v);
    af = ADDR_IN_W'(addr);
    wf = WORD_W'(val);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.voice <= vf;
    cmd_ch.sample_address <= af;
    cmd_ch.sample_value <= wf;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_cmd(op, vf, af, wf);
    counted_items++;
  endtask

  // Every word that an active voice is about to read is loaded first.
  task automatic play_frame();
    int p;
    for (int q = 0; q < VOICES; q++) begin
      if (voice_on[q]) begin
        for (int k = 0; k < 2; k++) begin
          p = voice_pos[q] + k;
          if (p < voice_len[q] && p < WORDS && !word_loaded[q][p])
            send_cmd(OP_LOAD, q, p, $urandom);
        end
      end
    end
    send_cmd(OP_FRAME, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_lengths(length_set_t lens);
    wait_idle();
    for (int i = 0; i < VOICES; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data <= CFG_DATA_W'(lens[i]);
      @(posedge clk);
      voice_len[i] = LENGTH_W'(lens[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_basic_playback();
    program_lengths('{4, 3, 2, 1, 0, 6});
    play_frame();
    send_cmd(OP_LOAD, 0, 0, 32767);
    send_cmd(OP_LOAD, 0, 1, -32768);
    send_cmd(OP_LOAD, 0, 2, -7);
    send_cmd(OP_LOAD, 0, 3, 7);
    send_cmd(OP_LOAD, 1, 0, -6);
    send_cmd(OP_LOAD, 1, 1, 6);
    send_cmd(OP_LOAD, 1, 2, 11);
    send_cmd(OP_LOAD, 2, 0, -5);
    send_cmd(OP_LOAD, 2, 1, 5);
    send_cmd(OP_LOAD, 3, 0, 12);
    send_cmd(OP_LOAD, 5, WORDS - 1, -1);
    send_cmd(OP_LOAD, 6, 0, 'h1234);
    send_cmd(OP_UNUSED, 0, 0, 32767);
    for (int v = 0; v < 8; v++) send_cmd(OP_TRIGGER, v, 0, 0);
    play_frame();
    play_frame();
    send_cmd(OP_TRIGGER, 0, 0, 0);
    repeat (3) play_frame();
  endtask

  task automatic test_full_scale();
    program_lengths('{2, 2, 2, 2, 2, 2});
    for (int v = 0; v < VOICES; v++) begin
      send_cmd(OP_LOAD, v, 0, 32767);
      send_cmd(OP_LOAD, v, 1, -32768);
      send_cmd(OP_TRIGGER, v, 0, 0);
    end
    play_frame();
    play_frame();
  endtask

  task automatic test_length_extremes();
    program_lengths('{WORDS, 32767, 0, 1, 2, WORDS});
    for (int v = 0; v < VOICES; v++) send_cmd(OP_TRIGGER, v, 0, 0);
    repeat (20) play_frame();
    send_cmd(OP_TRIGGER, 1, 0, 0);
    repeat (4) play_frame();
  endtask

  task automatic test_random_traffic();
    length_set_t lens;
    int phase_end;
    int r;
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int i = 0; i < VOICES; i++) lens[i] = pick_length();
      if (phase == 1) lens = '{0, 0, 0, 0, 0, 0};
      if (phase == 2) lens = '{WORDS, WORDS, WORDS, WORDS, WORDS, WORDS};
      program_lengths(lens);
      case (phase % 3)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 25;
          stall_pct = 25;
        end
        default: begin
          gap_pct = 60;
          stall_pct = 50;
        end
      endcase
      phase_end = counted_items + RANDOM_ITEMS / PHASES;
      while (counted_items < phase_end) begin
        r = $urandom_range(99);
        if (r < 40) begin
          play_frame();
        end else if (r < 58) begin
          send_cmd(OP_TRIGGER, $urandom_range(0, VOICES - 1), $urandom, $urandom);
        end else if (r < 60) begin
          send_cmd(OP_TRIGGER, $urandom_range(VOICES, 7), $urandom, $urandom);
        end else if (r < 85) begin
          send_cmd(OP_LOAD, $urandom_range(0, VOICES - 1), $urandom_range(0, 31), $urandom);
        end else if (r < 92) begin
          send_cmd(OP_LOAD, $urandom_range(0, VOICES - 1), $urandom, $urandom);
        end else if (r < 95) begin
          send_cmd(OP_LOAD, $urandom_range(VOICES, 7), $urandom, $urandom);
        end else if (r < 98) begin
          send_cmd(OP_UNUSED, $urandom, $urandom, $urandom);
        end else begin
          wait_idle();
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = OP_LOAD;
    cmd_ch.voice = '0;
    cmd_ch.sample_address = '0;
    cmd_ch.sample_value = '0;
    for (int v = 0; v < VOICES; v++) begin
      voice_len[v] = '0;
      voice_pos[v] = 0;
      voice_on[v] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_playback();
    test_full_scale();
    test_length_extremes();
    test_random_traffic();

    wait_idle();
    if (mismatches == 0 && mix_expected.size() == 0) begin
      $display("tb_one_shot_sample_voice_mixer OK");
    end else begin
      $display("tb_one_shot_sample_voice_mixer NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_one_shot_sample_voice_mixer NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/osvm_pkg.sv
src/osvm_if.sv
src/osvm_sample_ram.sv
src/osvm_div6.sv
src/one_shot_sample_voice_mixer.sv
verif/tb_one_shot_sample_voice_mixer.sv
